@@ hw/rtl/losbc_pkg.sv @@
// shared constants for the line-of-sight bitmap check unit
package losbc_pkg;

  // map geometry
  localparam int MAP_WIDTH  = 512;
  localparam int MAP_HEIGHT = 512;
  localparam int WORD_BITS  = 64;

  // bitmap storage
  localparam int MAP_WORDS  = (MAP_WIDTH * MAP_HEIGHT + WORD_BITS - 1) / WORD_BITS;
  localparam int WADDR_W    = $clog2(MAP_WORDS);
  localparam int BIT_W      = $clog2(WORD_BITS);

  // request field widths
  localparam int CMD_W      = 1;
  localparam int ADDR_W     = 12;
  localparam int DATA_W     = 64;
  localparam int COORD_W    = 9;

  // walk arithmetic
  localparam int IDX_W      = COORD_W + $clog2(MAP_WIDTH) + 1;
  localparam int ERR_W      = COORD_W + 3;
  localparam int CNT_W      = COORD_W + 1;

  // request command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

endpackage

@@ hw/rtl/losbc_map_ram.sv @@
// passability bitmap storage, one write port and one registered read port
module losbc_map_ram (
  input  logic                                clk_i,
  input  logic                                wr_en_i,
  input  logic [losbc_pkg::WADDR_W-1:0]       wr_addr_i,
  input  logic [losbc_pkg::WORD_BITS-1:0]     wr_data_i,
  input  logic                                rd_en_i,
  input  logic [losbc_pkg::WADDR_W-1:0]       rd_addr_i,
  output logic [losbc_pkg::WORD_BITS-1:0]     rd_data_o
);

  logic [losbc_pkg::WORD_BITS-1:0] mem [losbc_pkg::MAP_WORDS];
  logic [losbc_pkg::WORD_BITS-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ hw/rtl/line_of_sight_bitmap_check_unit.sv @@
// top level: bitmap writes and bresenham line-of-sight queries
//
// Takes one request at a time. A write (command 0) stores one 64-bit word of the
// passability bitmap (1 = passable) and its acknowledge is offered in the cycle
// after the request; a write beyond the map is dropped but still acknowledged.
// A query (command 1) walks the line from start to end, both end points
// included, and answers blocked as soon as an impassable pixel is found. The
// walk issues one bitmap read per pixel through the single read port of the
// bitmap memory and ends early when a pixel blocks. The next request is taken
// once the answer has been delivered. Words that were never written read as
// undefined; a query must not touch them.
module line_of_sight_bitmap_check_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [losbc_pkg::CMD_W-1:0]       command_i,
  input  logic [losbc_pkg::ADDR_W-1:0]      word_address_i,
  input  logic [losbc_pkg::DATA_W-1:0]      word_data_i,
  input  logic [losbc_pkg::COORD_W-1:0]     start_x_i,
  input  logic [losbc_pkg::COORD_W-1:0]     start_y_i,
  input  logic [losbc_pkg::COORD_W-1:0]     end_x_i,
  input  logic [losbc_pkg::COORD_W-1:0]     end_y_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              is_query_answer_o,
  output logic                              line_blocked_o
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SETUP  = 4'b0010,
    S_WALK   = 4'b0100,
    S_RESULT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [losbc_pkg::COORD_W-1:0]   x_q, x_d, y_q, y_d;
  logic [losbc_pkg::COORD_W-1:0]   ex_q, ey_q;
  logic [losbc_pkg::COORD_W-1:0]   a_q, a_d, b_q, b_d;
  logic                            xmaj_q, xmaj_d, sxn_q, sxn_d, syn_q, syn_d;
  logic [losbc_pkg::ERR_W-1:0]     err_q, err_d;
  logic [losbc_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic                            pend_q, pend_d, oob_q, oob_d;
  logic [losbc_pkg::BIT_W-1:0]     bit_q, bit_d;
  logic                            isq_q, isq_d, blk_q, blk_d;

  logic                            in_accept;
  logic                            wr_en;
  logic                            rd_en;
  logic [losbc_pkg::WADDR_W-1:0]   rd_addr;
  logic [losbc_pkg::WORD_BITS-1:0] rd_data;

  // setup arithmetic
  logic signed [losbc_pkg::COORD_W:0] dx, dy;
  logic [losbc_pkg::COORD_W-1:0]      adx, ady, a_n, b_n;

  // per-pixel address arithmetic
  logic [losbc_pkg::IDX_W-1:0]        pix, word;
  logic                               pix_oob;
  logic                               pix_pass;
  logic [losbc_pkg::ERR_W-1:0]        two_a, two_b;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_RESULT);
  assign is_query_answer_o = isq_q;
  assign line_blocked_o = blk_q;

  // bitmap write straight from the request
  assign wr_en = in_accept && (losbc_pkg::cmd_e'(command_i) == losbc_pkg::CMD_WRITE)
                 && (32'(word_address_i) < losbc_pkg::MAP_WORDS);

  losbc_map_ram u_map_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (losbc_pkg::WADDR_W'(word_address_i)),
    .wr_data_i (word_data_i[losbc_pkg::WORD_BITS-1:0]),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // deltas and the major and minor axis lengths
  always_comb begin
    dx  = $signed({1'b0, ex_q}) - $signed({1'b0, x_q});
    dy  = $signed({1'b0, ey_q}) - $signed({1'b0, y_q});
    adx = dx[losbc_pkg::COORD_W] ? losbc_pkg::COORD_W'(-dx) : dx[losbc_pkg::COORD_W-1:0];
    ady = dy[losbc_pkg::COORD_W] ? losbc_pkg::COORD_W'(-dy) : dy[losbc_pkg::COORD_W-1:0];
    a_n = (adx >= ady) ? adx : ady;
    b_n = (adx >= ady) ? ady : adx;
  end

  // pixel index, word address and map bounds of the current pixel
  always_comb begin
    pix      = losbc_pkg::IDX_W'(y_q) * losbc_pkg::IDX_W'(losbc_pkg::MAP_WIDTH)
               + losbc_pkg::IDX_W'(x_q);
    word     = losbc_pkg::IDX_W'(pix / losbc_pkg::WORD_BITS);
    pix_oob  = (32'(x_q) >= losbc_pkg::MAP_WIDTH) || (32'(y_q) >= losbc_pkg::MAP_HEIGHT)
               || (32'(word) >= losbc_pkg::MAP_WORDS);
    rd_addr  = losbc_pkg::WADDR_W'(word);
    pix_pass = !oob_q && rd_data[bit_q];
    two_a    = {2'b00, a_q, 1'b0};
    two_b    = {2'b00, b_q, 1'b0};
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    x_d     = x_q;
    y_d     = y_q;
    a_d     = a_q;
    b_d     = b_q;
    xmaj_d  = xmaj_q;
    sxn_d   = sxn_q;
    syn_d   = syn_q;
    err_d   = err_q;
    cnt_d   = cnt_q;
    pend_d  = pend_q;
    oob_d   = oob_q;
    bit_d   = bit_q;
    isq_d   = isq_q;
    blk_d   = blk_q;
    rd_en   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          if (losbc_pkg::cmd_e'(command_i) == losbc_pkg::CMD_QUERY) begin
            state_d = S_SETUP;
          end else begin
            state_d = S_RESULT;
            isq_d   = 1'b0;
            blk_d   = 1'b0;
          end
        end
      end
      S_SETUP: begin
        xmaj_d  = (adx >= ady);
        sxn_d   = dx[losbc_pkg::COORD_W];
        syn_d   = dy[losbc_pkg::COORD_W];
        a_d     = a_n;
        b_d     = b_n;
        err_d   = {2'b00, b_n, 1'b0} - {3'b000, a_n};
        cnt_d   = losbc_pkg::CNT_W'(a_n) + losbc_pkg::CNT_W'(1);
        pend_d  = 1'b0;
        state_d = S_WALK;
      end
      S_WALK: begin
        // test the pixel read in the previous cycle
        if (pend_q && !pix_pass) begin
          state_d = S_RESULT;
          isq_d   = 1'b1;
          blk_d   = 1'b1;
        end else if (cnt_q == '0) begin
          state_d = S_RESULT;
          isq_d   = 1'b1;
          blk_d   = 1'b0;
        end
        // issue the read for the current pixel and step along the line
        if (cnt_q != '0) begin
          rd_en  = 1'b1;
          pend_d = 1'b1;
          oob_d  = pix_oob;
          bit_d  = losbc_pkg::BIT_W'(pix % losbc_pkg::WORD_BITS);
          cnt_d  = cnt_q - losbc_pkg::CNT_W'(1);
          if (!err_q[losbc_pkg::ERR_W-1]) begin
            err_d = err_q + two_b - two_a;
            if (xmaj_q) begin
              y_d = syn_q ? y_q - losbc_pkg::COORD_W'(1) : y_q + losbc_pkg::COORD_W'(1);
            end else begin
              x_d = sxn_q ? x_q - losbc_pkg::COORD_W'(1) : x_q + losbc_pkg::COORD_W'(1);
            end
          end else begin
            err_d = err_q + two_b;
          end
          if (xmaj_q) begin
            x_d = sxn_q ? x_q - losbc_pkg::COORD_W'(1) : x_q + losbc_pkg::COORD_W'(1);
          end else begin
            y_d = syn_q ? y_q - losbc_pkg::COORD_W'(1) : y_q + losbc_pkg::COORD_W'(1);
          end
        end else begin
          pend_d = 1'b0;
        end
      end
      S_RESULT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pend_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      cnt_q   <= cnt_d;
    end
  end

  // walk datapath and answer registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      x_q  <= start_x_i;
      y_q  <= start_y_i;
      ex_q <= end_x_i;
      ey_q <= end_y_i;
    end else begin
      x_q  <= x_d;
      y_q  <= y_d;
    end
    a_q    <= a_d;
    b_q    <= b_d;
    xmaj_q <= xmaj_d;
    sxn_q  <= sxn_d;
    syn_q  <= syn_d;
    err_q  <= err_d;
    oob_q  <= oob_d;
    bit_q  <= bit_d;
    isq_q  <= isq_d;
    blk_q  <= blk_d;
  end

`ifndef SYNTHESIS
  // a write acknowledge never reports a blocked line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_query_answer_o |-> !line_blocked_o)
    else $error("write acknowledge reports blocked");

  // the unit is busy in the cycle after taking a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("request taken while busy");

  // the walk never issues more reads than the line has pixels
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WALK |-> cnt_q <= losbc_pkg::CNT_W'(a_q) + losbc_pkg::CNT_W'(1))
    else $error("walk pixel count out of range");

  // a held answer keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(line_blocked_o)
    && $stable(is_query_answer_o))
    else $error("stalled answer changed");
`endif

endmodule

@@ tb/tb_line_of_sight_bitmap_check_unit.sv @@
// testbench for the line-of-sight bitmap check unit
module tb_line_of_sight_bitmap_check_unit;

  localparam logic [losbc_pkg::DATA_W-1:0] ALL_OPEN = '1;
  localparam int COORD_MAX    = (1 << losbc_pkg::COORD_W) - 1;
  localparam int ITEM_COUNT   = 400;
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 600;
  localparam int PRINT_LIMIT  = 100;

  // how a bitmap word gets filled when a query needs it loaded first
  typedef enum int {FILL_OPEN, FILL_SPARSE, FILL_NOISE} fill_style_e;

  typedef struct packed {
    logic [losbc_pkg::CMD_W-1:0]   command;
    logic [losbc_pkg::ADDR_W-1:0]  word_address;
    logic [losbc_pkg::DATA_W-1:0]  word_data;
    logic [losbc_pkg::COORD_W-1:0] start_x;
    logic [losbc_pkg::COORD_W-1:0] start_y;
    logic [losbc_pkg::COORD_W-1:0] end_x;
    logic [losbc_pkg::COORD_W-1:0] end_y;
  } los_request_t;

  typedef struct packed {
    logic is_query_answer;
    logic line_blocked;
  } los_answer_t;

  logic                          clk_i          = 1'b0;
  logic                          rst_ni         = 1'b0;
  logic                          in_valid_i     = 1'b0;
  logic                          in_stall_o;
  logic [losbc_pkg::CMD_W-1:0]   command_i      = '0;
  logic [losbc_pkg::ADDR_W-1:0]  word_address_i = '0;
  logic [losbc_pkg::DATA_W-1:0]  word_data_i    = '0;
  logic [losbc_pkg::COORD_W-1:0] start_x_i      = '0;
  logic [losbc_pkg::COORD_W-1:0] start_y_i      = '0;
  logic [losbc_pkg::COORD_W-1:0] end_x_i        = '0;
  logic [losbc_pkg::COORD_W-1:0] end_y_i        = '0;
  logic                          out_valid_o;
  logic                          out_stall_i    = 1'b0;
  logic                          is_query_answer_o;
  logic                          line_blocked_o;

  los_request_t                  pending_requests[$];
  los_answer_t                   expected_answers[$];
  los_request_t                  held_request;
  los_answer_t                   oldest_answer;
  logic [losbc_pkg::DATA_W-1:0]  map_image [losbc_pkg::MAP_WORDS];
  bit                            word_loaded [losbc_pkg::MAP_WORDS];
  int                            traced_pixels[$];
  int                            queued_items   = 0;
  int                            send_idle_pct  = 10;
  int                            recv_stall_pct = 60;
  int                            mismatch_count = 0;
  int                            quiet_cycles   = 0;

  line_of_sight_bitmap_check_unit uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .command_i         (command_i),
    .word_address_i    (word_address_i),
    .word_data_i       (word_data_i),
    .start_x_i         (start_x_i),
    .start_y_i         (start_y_i),
    .end_x_i           (end_x_i),
    .end_y_i           (end_y_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .is_query_answer_o (is_query_answer_o),
    .line_blocked_o    (line_blocked_o)
  );

  always #4 clk_i = ~clk_i;

  // bresenham walk, leaves the pixel indices of the line in traced_pixels
  function automatic void trace_line(int x0, int y0, int x1, int y1);
    int adx, ady, sx, sy, a, b, err, x, y, n;
    bit x_major;
    adx = (x1 >= x0) ? x1 - x0 : x0 - x1;
    ady = (y1 >= y0) ? y1 - y0 : y0 - y1;
    sx = (x1 < x0) ? -1 : 1;
    sy = (y1 < y0) ? -1 : 1;
    x_major = adx >= ady;
    a = x_major ? adx : ady;
    b = x_major ? ady : adx;
    err = 2 * b - a;
    x = x0;
    y = y0;
    traced_pixels.delete();
    for (n = 0; n <= a; n++) begin
      traced_pixels.push_back(y * losbc_pkg::MAP_WIDTH + x);
      if (err >= 0) begin
        if (x_major) y += sy;
        else x += sx;
        err += 2 * b - 2 * a;
      end else begin
        err += 2 * b;
      end
      if (x_major) x += sx;
      else y += sy;
    end
  endfunction

  // first impassable pixel on the line answers blocked
  function automatic logic line_blocked_in_map(los_request_t req);
    int idx;
    trace_line(int'(req.start_x), int'(req.start_y), int'(req.end_x), int'(req.end_y));
    foreach (traced_pixels[i]) begin
      idx = traced_pixels[i];
      if (!map_image[idx / losbc_pkg::WORD_BITS][idx % losbc_pkg::WORD_BITS]) return 1'b1;
    end
    return 1'b0;
  endfunction

  // update the map copy and queue the answer for an accepted request
  function automatic void record_request(los_request_t req);
    los_answer_t ans;
    if (req.command == losbc_pkg::CMD_WRITE) begin
      if (int'(req.word_address) < losbc_pkg::MAP_WORDS) begin
        map_image[req.word_address] = req.word_data;
      end
      ans.is_query_answer = 1'b0;
      ans.line_blocked = 1'b0;
    end else begin
      ans.is_query_answer = 1'b1;
      ans.line_blocked = line_blocked_in_map(req);
    end
    expected_answers.push_back(ans);
  endfunction

  function automatic logic [losbc_pkg::DATA_W-1:0] fill_word(fill_style_e style);
    case (style)
      FILL_OPEN: begin
        return ALL_OPEN;
      end
      // roughly one pixel in sixteen impassable
      FILL_SPARSE: begin
        return ~({$urandom, $urandom} & {$urandom, $urandom} &
                 {$urandom, $urandom} & {$urandom, $urandom});
      end
      default: begin
        return {$urandom, $urandom};
      end
    endcase
  endfunction

  // end point a short random distance away, kept on the map
  function automatic int near_coord(int c);
    int v;
    v = c + int'($urandom_range(30)) - 15;
    if (v < 0) v = 0;
    if (v > COORD_MAX) v = COORD_MAX;
    return v;
  endfunction

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) $display("mismatch at %0t: %s", $realtime, what);
  endtask

  task automatic queue_word_write(int addr, logic [losbc_pkg::DATA_W-1:0] data);
    los_request_t req;
    req.command      = losbc_pkg::CMD_WRITE;
    req.word_address = losbc_pkg::ADDR_W'(addr);
    req.word_data    = data;
    req.start_x      = losbc_pkg::COORD_W'($urandom_range(COORD_MAX));
    req.start_y      = losbc_pkg::COORD_W'($urandom_range(COORD_MAX));
    req.end_x        = losbc_pkg::COORD_W'($urandom_range(COORD_MAX));
    req.end_y        = losbc_pkg::COORD_W'($urandom_range(COORD_MAX));
    pending_requests.push_back(req);
    queued_items++;
    word_loaded[addr] = 1'b1;
  endtask

  // a query, preceded by writes of any word on its line not yet loaded
  task automatic queue_line_query(int x0, int y0, int x1, int y1, fill_style_e style);
    los_request_t req;
    int word_idx;
    trace_line(x0, y0, x1, y1);
    foreach (traced_pixels[i]) begin
      word_idx = traced_pixels[i] / losbc_pkg::WORD_BITS;
      if (!word_loaded[word_idx]) queue_word_write(word_idx, fill_word(style));
    end
    req.command      = losbc_pkg::CMD_QUERY;
    req.word_address = losbc_pkg::ADDR_W'($urandom_range((1 << losbc_pkg::ADDR_W) - 1));
    req.word_data    = {$urandom, $urandom};
    req.start_x      = losbc_pkg::COORD_W'(x0);
    req.start_y      = losbc_pkg::COORD_W'(y0);
    req.end_x        = losbc_pkg::COORD_W'(x1);
    req.end_y        = losbc_pkg::COORD_W'(y1);
    pending_requests.push_back(req);
    queued_items++;
  endtask

  task automatic queue_directed_items();
    // row 0 with one hole at x=5, bottom-right corner open, bottom-left run shut
    queue_word_write(0, ALL_OPEN & ~(64'd1 << 5));
    queue_word_write(losbc_pkg::MAP_WORDS - 1, ALL_OPEN);
    queue_word_write(losbc_pkg::MAP_WORDS - 8, '0);
    // single pixel, impassable then passable
    queue_line_query(5, 0, 5, 0, FILL_OPEN);
    queue_line_query(4, 0, 4, 0, FILL_OPEN);
    // horizontal through the hole, both directions, then past it
    queue_line_query(0, 0, 10, 0, FILL_OPEN);
    queue_line_query(10, 0, 0, 0, FILL_OPEN);
    queue_line_query(6, 0, 63, 0, FILL_OPEN);
    queue_line_query(COORD_MAX, COORD_MAX, 448, COORD_MAX, FILL_OPEN);
    // full bottom row, blocked at once and blocked late
    queue_line_query(0, COORD_MAX, COORD_MAX, COORD_MAX, FILL_OPEN);
    queue_line_query(COORD_MAX, COORD_MAX, 0, COORD_MAX, FILL_OPEN);
    // diagonals with equal deltas, one blocked only at its far end point
    queue_line_query(COORD_MAX - 20, COORD_MAX - 20, COORD_MAX, COORD_MAX, FILL_OPEN);
    queue_line_query(20, COORD_MAX - 20, 0, COORD_MAX, FILL_OPEN);
    // column down to the shut run, then one short of it
    queue_line_query(0, COORD_MAX - 30, 0, COORD_MAX, FILL_OPEN);
    queue_line_query(0, COORD_MAX - 30, 0, COORD_MAX - 1, FILL_OPEN);
    // steep, shallow backwards, and a negative x tie
    queue_line_query(100, 200, 103, 220, FILL_OPEN);
    queue_line_query(300, 50, 280, 47, FILL_OPEN);
    queue_line_query(200, 300, 190, 310, FILL_OPEN);
    // reopen the holes and walk the same lines clear
    queue_word_write(0, ALL_OPEN);
    queue_word_write(losbc_pkg::MAP_WORDS - 8, ALL_OPEN);
    queue_line_query(0, 0, 10, 0, FILL_OPEN);
    queue_line_query(0, COORD_MAX, COORD_MAX, COORD_MAX, FILL_OPEN);
  endtask

  // random requests until the running total of queued requests reaches target
  task automatic queue_random_items(int target);
    int x0, y0, x1, y1, roll;
    fill_style_e style;
    while (queued_items < target) begin
      roll  = $urandom_range(99);
      style = fill_style_e'($urandom_range(2));
      if (roll < 30) begin
        queue_word_write(int'($urandom_range(losbc_pkg::MAP_WORDS - 1)), fill_word(style));
      end else begin
        x0 = $urandom_range(COORD_MAX);
        y0 = $urandom_range(COORD_MAX);
        // mostly short lines, a few shallow ones across the map, some single pixels
        if (roll < 38) begin
          x1 = $urandom_range(COORD_MAX);
          y1 = near_coord(y0);
        end else if (roll < 43) begin
          x1 = x0;
          y1 = y0;
        end else begin
          x1 = near_coord(x0);
          y1 = near_coord(y0);
        end
        queue_line_query(x0, y0, x1, y1, style);
      end
    end
  endtask

  task automatic wait_until_drained();
    while (pending_requests.size() != 0 || in_valid_i || expected_answers.size() != 0)
      @(posedge clk_i);
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      command_i      <= '0;
      word_address_i <= '0;
      word_data_i    <= '0;
      start_x_i      <= '0;
      start_y_i      <= '0;
      end_x_i        <= '0;
      end_y_i        <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) record_request(held_request);
      if (!in_valid_i || !in_stall_o) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          held_request = pending_requests.pop_front();
          in_valid_i     <= 1'b1;
          command_i      <= held_request.command;
          word_address_i <= held_request.word_address;
          word_data_i    <= held_request.word_data;
          start_x_i      <= held_request.start_x;
          start_y_i      <= held_request.start_y;
          end_x_i        <= held_request.end_x;
          end_y_i        <= held_request.end_y;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // answer monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_answers.size() == 0) begin
          report_mismatch("answer with no request outstanding");
        end else begin
          oldest_answer = expected_answers.pop_front();
          if (is_query_answer_o !== oldest_answer.is_query_answer)
            report_mismatch($sformatf("is_query_answer %b, expected %b",
                                      is_query_answer_o, oldest_answer.is_query_answer));
          if (line_blocked_o !== oldest_answer.line_blocked)
            report_mismatch($sformatf("line_blocked %b, expected %b",
                                      line_blocked_o, oldest_answer.line_blocked));
        end
      end
      out_stall_i <= $urandom_range(99) < recv_stall_pct;
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("line_of_sight_bitmap_check_unit test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // reset, then three phases of traffic with different idle and stall percentages, then the final verdict
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    queue_directed_items();
    queue_random_items(ITEM_COUNT / 2);
    wait_until_drained();
    send_idle_pct  = 60;
    recv_stall_pct = 10;
    queue_random_items((3 * ITEM_COUNT) / 4);
    wait_until_drained();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    queue_random_items(ITEM_COUNT);
    wait_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_answers.size() == 0) begin
      $display("line_of_sight_bitmap_check_unit test passed");
    end else begin
      $display("line_of_sight_bitmap_check_unit test failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/losbc_pkg.sv
hw/rtl/losbc_map_ram.sv
hw/rtl/line_of_sight_bitmap_check_unit.sv
tb/tb_line_of_sight_bitmap_check_unit.sv
